FILE: rtl/ssf_pkg.sv
package ssf_pkg;

    localparam int IN_TDATA_W  = 224;
    localparam int OUT_TDATA_W = 112;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SELF_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_RADIUS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_DISTANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_WEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP      = 3'd6;

    localparam logic ACT_BEGIN    = 1'b0;
    localparam logic ACT_NEIGHBOR = 1'b1;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [5:0] K_RATIO = 6'd17;
    localparam logic [5:0] K_SCALE = 6'd48;
    localparam logic [5:0] K_UNIT  = 6'd17;
    localparam logic [5:0] K_MEAN  = 6'd32;
    localparam logic [5:0] SQRT_STEPS = 6'd32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_GAP,
        ST_DIV,
        ST_R2,
        ST_WT,
        ST_SSAVE,
        ST_UMUL,
        ST_UACC,
        ST_FIN,
        ST_FSAVE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_RATIO,
        OP_SCALE,
        OP_UNIT,
        OP_MEAN
    } div_op_t;

    typedef struct packed {
        logic        start;
        div_op_t     op;
        logic [63:0] num;
        logic [33:0] den;
        logic [5:0]  k;
    } div_load_t;

endpackage

FILE: rtl/separation_steering_force.sv
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  tdata: neighbor/begin fields, tuser: action, tlast: last
// m_       out  m_tvalid/m_tready  tdata: force_x, force_y, force_z, used_count
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A begin item, an inactive neighbor or one past the count limit goes no further; an active
// neighbor runs 3 squares and 32 root steps to its gap check, and if it counts, the shared
// one-bit-per-cycle divider then runs 17 + 48 + 3 x 17 steps.
// A last item then adds the final and output states, and three 32-step means if a neighbor counted.
// Reset (aresetn low, synchronous) clears accumulators and count, loads register defaults.
// The result sits in an output register; a stalled m_ side holds only the next result.
module separation_steering_force #(
    parameter int MAX_NEIGHBORS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // init_fx, init_fy, init_fz, pos_x, pos_y, pos_z, radius(31), active(1)
    input  logic [ssf_pkg::IN_TDATA_W-1:0]  s_tdata,
    // action
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // force_x, force_y, force_z, used_count(9), zero fill
    output logic [ssf_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ssf_pkg::*;

    localparam logic [8:0] CNT_LIMIT =
        (MAX_NEIGHBORS < 511) ? 9'(MAX_NEIGHBORS) : 9'd511;

    // configuration
    logic signed [31:0] self_x_reg, self_y_reg, self_z_reg, sep_weight_reg;
    logic [30:0]        self_radius_reg, sep_dist_reg, min_gap_reg;

    state_t state_reg, state_next;
    logic signed [31:0] acc_reg [3];
    logic [8:0]         cnt_reg;
    logic signed [32:0] d_reg [3];
    logic [30:0]        nb_radius_reg;
    logic               last_reg;
    logic [1:0]         ax_reg;
    logic [65:0]        sumsq_reg;
    logic [63:0]        sq_n_reg;
    logic               dbl_reg;
    logic [31:0]        root_reg;
    logic [33:0]        srem_reg;
    logic [5:0]         iter_reg;
    logic [32:0]        len_reg;
    logic [30:0]        gap_reg;
    div_op_t            div_op_reg;
    logic [33:0]        div_rem_reg, div_den_reg;
    logic [63:0]        div_sh_reg;
    logic [47:0]        div_q_reg;
    logic [16:0]        f_reg;
    logic signed [48:0] s_reg;
    logic signed [50:0] p1_reg;
    logic signed [34:0] p2_reg;
    logic signed [31:0] res_reg [3];
    logic               m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    logic        s_fire;
    div_load_t   ld;
    logic [32:0] dmag [3];
    logic [31:0] accmag [3];

    // field views
    logic signed [31:0] in_f [3];
    logic signed [31:0] in_p [3];
    logic [30:0]        in_radius;
    logic               in_active;

    assign in_f[0]   = s_tdata[31:0];
    assign in_f[1]   = s_tdata[63:32];
    assign in_f[2]   = s_tdata[95:64];
    assign in_p[0]   = s_tdata[127:96];
    assign in_p[1]   = s_tdata[159:128];
    assign in_p[2]   = s_tdata[191:160];
    assign in_radius = s_tdata[222:192];
    assign in_active = s_tdata[223];

    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dmag[i]   = d_reg[i][32] ? 33'(-d_reg[i]) : 33'(d_reg[i]);
            accmag[i] = acc_reg[i][31] ? 32'(-acc_reg[i]) : 32'(acc_reg[i]);
        end
    end

    // squares
    logic [65:0] sq_c, sum_c;
    assign sq_c  = 66'(dmag[ax_reg] * dmag[ax_reg]);
    assign sum_c = sumsq_reg + sq_c;

    // square root step: two radicand bits per cycle
    logic [35:0] st_c, trial_c;
    logic        sq_ge;
    assign st_c    = {srem_reg, sq_n_reg[63:62]};
    assign trial_c = {2'b00, root_reg, 2'b01};
    assign sq_ge   = st_c >= trial_c;

    // gap check
    logic [32:0]        len_c;
    logic signed [34:0] gap_c;
    logic [30:0]        mg_c;
    logic               pass_c;
    assign len_c = dbl_reg ? {root_reg, 1'b0} : {1'b0, root_reg};
    assign gap_c = $signed({2'b00, len_c}) - $signed({4'b0000, self_radius_reg})
                   - $signed({4'b0000, nb_radius_reg});
    assign mg_c  = (min_gap_reg == '0) ? 31'd1 : min_gap_reg;
    assign pass_c = (gap_c >= $signed({4'b0000, mg_c}))
                 && (gap_c <= $signed({4'b0000, sep_dist_reg}))
                 && (len_c != '0);

    // divider step: restoring, one quotient bit per cycle
    logic [34:0] dt_c;
    logic        dv_ge;
    assign dt_c  = {div_rem_reg, div_sh_reg[63]};
    assign dv_ge = dt_c >= {1'b0, div_den_reg};

    // falloff and weight
    logic [33:0]        rr_c;
    logic signed [49:0] wp_c;
    logic signed [33:0] wt_c;
    logic [31:0]        wt_mag_c;
    assign rr_c     = 34'(div_q_reg[16:0] * div_q_reg[16:0]);
    assign wp_c     = 50'(sep_weight_reg * $signed({1'b0, f_reg}));
    assign wt_c     = wp_c[49:16];
    assign wt_mag_c = wt_c[33] ? 32'(-wt_c) : 32'(wt_c);

    // push products
    logic signed [17:0] u_c;
    logic signed [50:0] c_c;
    logic signed [51:0] accsum_c;
    logic signed [31:0] accsat_c;
    assign u_c = d_reg[ax_reg][32] ? -$signed({1'b0, div_q_reg[16:0]})
                                   : $signed({1'b0, div_q_reg[16:0]});
    assign c_c = p1_reg + 51'(p2_reg >>> 16);
    assign accsum_c = 52'(acc_reg[ax_reg]) + 52'(c_c);
    always_comb begin
        if (accsum_c > 52'sd2147483647)
            accsat_c = 32'sh7FFFFFFF;
        else if (accsum_c < -52'sd2147483648)
            accsat_c = 32'sh80000000;
        else
            accsat_c = accsum_c[31:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == ACT_NEIGHBOR && in_active && cnt_reg < CNT_LIMIT)
                        state_next = ST_SQ;
                    else if (s_tlast)
                        state_next = ST_FIN;
                end
            end
            ST_SQ:    if (ax_reg == 2'd2) state_next = ST_SQRT;
            ST_SQRT:  if (iter_reg == '0) state_next = ST_GAP;
            ST_GAP: begin
                if (pass_c)
                    state_next = ST_DIV;
                else
                    state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_DIV: begin
                if (iter_reg == '0) begin
                    case (div_op_reg)
                        OP_RATIO: state_next = ST_R2;
                        OP_SCALE: state_next = ST_SSAVE;
                        OP_UNIT:  state_next = ST_UMUL;
                        default:  state_next = ST_FSAVE;
                    endcase
                end
            end
            ST_R2:    state_next = ST_WT;
            ST_WT:    state_next = ST_DIV;
            ST_SSAVE: state_next = ST_DIV;
            ST_UMUL:  state_next = ST_UACC;
            ST_UACC: begin
                if (ax_reg != 2'd2)
                    state_next = ST_DIV;
                else
                    state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:   state_next = (cnt_reg == '0) ? ST_OUT : ST_DIV;
            ST_FSAVE: state_next = (ax_reg == 2'd2) ? ST_OUT : ST_DIV;
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and divider loads
    always_comb begin
        s_tready = 1'b0;
        ld       = '0;
        ld.op    = OP_RATIO;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_GAP: begin
                ld.start = pass_c;
                ld.op    = OP_RATIO;
                ld.num   = {17'd0, gap_c[30:0], 16'd0};
                ld.den   = {3'd0, sep_dist_reg};
                ld.k     = K_RATIO;
            end
            ST_WT: begin
                ld.start = 1'b1;
                ld.op    = OP_SCALE;
                ld.num   = {16'd0, wt_mag_c, 16'd0};
                ld.den   = {3'd0, gap_reg};
                ld.k     = K_SCALE;
            end
            ST_SSAVE: begin
                ld.start = 1'b1;
                ld.op    = OP_UNIT;
                ld.num   = {15'd0, dmag[0], 16'd0};
                ld.den   = {1'b0, len_reg};
                ld.k     = K_UNIT;
            end
            ST_UACC: begin
                ld.start = (ax_reg != 2'd2);
                ld.op    = OP_UNIT;
                ld.num   = {15'd0, dmag[2'(ax_reg + 2'd1)], 16'd0};
                ld.den   = {1'b0, len_reg};
                ld.k     = K_UNIT;
            end
            ST_FIN: begin
                ld.start = (cnt_reg != '0);
                ld.op    = OP_MEAN;
                ld.num   = {32'd0, accmag[0]};
                ld.den   = {25'd0, cnt_reg};
                ld.k     = K_MEAN;
            end
            ST_FSAVE: begin
                ld.start = (ax_reg != 2'd2);
                ld.op    = OP_MEAN;
                ld.num   = {32'd0, accmag[2'(ax_reg + 2'd1)]};
                ld.den   = {25'd0, cnt_reg};
                ld.k     = K_MEAN;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            cnt_reg         <= '0;
            acc_reg[0]      <= '0;
            acc_reg[1]      <= '0;
            acc_reg[2]      <= '0;
            self_x_reg      <= '0;
            self_y_reg      <= '0;
            self_z_reg      <= '0;
            self_radius_reg <= '0;
            sep_dist_reg    <= 31'd65536;
            sep_weight_reg  <= 32'sd65536;
            min_gap_reg     <= 31'd1;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_SELF_X:       self_x_reg      <= cfg_data;
                    REG_SELF_Y:       self_y_reg      <= cfg_data;
                    REG_SELF_Z:       self_z_reg      <= cfg_data;
                    REG_SELF_RADIUS:  self_radius_reg <= cfg_data[30:0];
                    REG_SEP_DISTANCE: sep_dist_reg    <= cfg_data[30:0];
                    REG_SEP_WEIGHT:   sep_weight_reg  <= cfg_data;
                    REG_MIN_GAP:      min_gap_reg     <= cfg_data[30:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && state_reg != ST_OUT)
                m_tvalid_reg <= 1'b0;

            if (state_reg == ST_IDLE && s_fire && s_tuser == ACT_BEGIN) begin
                acc_reg[0] <= in_f[0];
                acc_reg[1] <= in_f[1];
                acc_reg[2] <= in_f[2];
                cnt_reg    <= '0;
            end

            if (state_reg == ST_UACC) begin
                acc_reg[ax_reg] <= accsat_c;
                if (ax_reg == 2'd2)
                    cnt_reg <= cnt_reg + 9'd1;
            end

            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
                acc_reg[0]   <= '0;
                acc_reg[1]   <= '0;
                acc_reg[2]   <= '0;
                cnt_reg      <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_fire) begin
            d_reg[0]      <= 33'(self_x_reg) - 33'(in_p[0]);
            d_reg[1]      <= 33'(self_y_reg) - 33'(in_p[1]);
            d_reg[2]      <= 33'(self_z_reg) - 33'(in_p[2]);
            nb_radius_reg <= in_radius;
            last_reg      <= s_tlast;
            ax_reg        <= '0;
            sumsq_reg     <= '0;
        end

        case (state_reg)
            ST_SQ: begin
                sumsq_reg <= sum_c;
                ax_reg    <= ax_reg + 2'd1;
                if (ax_reg == 2'd2) begin
                    // beyond 64 bits, take the root of a quarter and double it
                    if (sum_c[65:64] == 2'b00) begin
                        sq_n_reg <= sum_c[63:0];
                        dbl_reg  <= 1'b0;
                    end else begin
                        sq_n_reg <= sum_c[65:2];
                        dbl_reg  <= 1'b1;
                    end
                    root_reg <= '0;
                    srem_reg <= '0;
                    iter_reg <= SQRT_STEPS - 6'd1;
                end
            end
            ST_SQRT: begin
                sq_n_reg <= {sq_n_reg[61:0], 2'b00};
                iter_reg <= iter_reg - 6'd1;
                if (sq_ge) begin
                    srem_reg <= 34'(st_c - trial_c);
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    srem_reg <= st_c[33:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            ST_GAP: begin
                len_reg <= len_c;
                gap_reg <= gap_c[30:0];
            end
            ST_DIV: begin
                div_sh_reg <= {div_sh_reg[62:0], 1'b0};
                div_q_reg  <= {div_q_reg[46:0], dv_ge};
                div_rem_reg <= dv_ge ? 34'(dt_c - {1'b0, div_den_reg}) : dt_c[33:0];
                iter_reg   <= iter_reg - 6'd1;
            end
            ST_R2: f_reg <= ONE_Q16 - rr_c[32:16];
            // hold only the sign of the weight until the scale quotient is in
            ST_WT: s_reg <= wt_c[33] ? -49'sd1 : 49'sd0;
            ST_SSAVE: begin
                s_reg  <= s_reg[48] ? -$signed({1'b0, div_q_reg})
                                    : $signed({1'b0, div_q_reg});
                ax_reg <= '0;
            end
            ST_UMUL: begin
                p1_reg <= 51'(u_c * $signed(s_reg[48:16]));
                p2_reg <= 35'(u_c * $signed({1'b0, s_reg[15:0]}));
            end
            ST_UACC: if (ax_reg != 2'd2) ax_reg <= ax_reg + 2'd1;
            ST_FIN: begin
                ax_reg     <= '0;
                res_reg[0] <= acc_reg[0];
                res_reg[1] <= acc_reg[1];
                res_reg[2] <= acc_reg[2];
            end
            ST_FSAVE: begin
                res_reg[ax_reg] <= acc_reg[ax_reg][31] ? -$signed(div_q_reg[31:0])
                                                       : $signed(div_q_reg[31:0]);
                if (ax_reg != 2'd2) ax_reg <= ax_reg + 2'd1;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready)
                    m_data_reg <= {7'd0, cnt_reg, res_reg[2], res_reg[1], res_reg[0]};
            end
            default: ;
        endcase

        // load the shared divider, first bits of the quotient already in place
        if (ld.start) begin
            div_op_reg  <= ld.op;
            div_den_reg <= ld.den;
            div_rem_reg <= 34'(ld.num >> ld.k);
            div_sh_reg  <= ld.num << (7'd64 - {1'b0, ld.k});
            div_q_reg   <= '0;
            iter_reg    <= ld.k - 6'd1;
        end
    end

endmodule

FILE: verif/separation_steering_force_test.sv
`default_nettype none

module separation_steering_force_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int COUNT_LIMIT = 256;
    localparam int RANDOM_ITEMS = 1650;

    typedef struct {
        logic        act;
        logic [31:0] f0, f1, f2;   // initial force on begin, position on neighbor
        logic [30:0] rad;
        logic        active, last, chk;
        logic [31:0] ex, ey, ez;
        logic [8:0]  ecnt;
    } stim_row_t;

    typedef struct {
        logic [31:0] fx, fy, fz;
        logic [8:0]  cnt;
    } force_res_t;

    typedef struct {
        logic       typed;
        force_res_t res;
    } typed_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    separation_steering_force dut (.*);

    // predictor state
    longint self_pos[3];
    longint self_rad, sep_dist, sep_wt, gap_min;
    longint acc[3];
    int     used_cnt;

    force_res_t force_q[$];
    typed_res_t typed_q[$];
    int err_count = 0;
    int burst_left = 0;
    bit hold_req = 0;
    int sent = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("separation_steering_force_test NOT OK");
        $finish;
    end

    task automatic report(input string what, input longint exp_v, input longint got_v);
        $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $realtime);
        err_count++;
    endtask

    function automatic longint sqrt_floor(input bit [63:0] n);
        bit [63:0] r = 0;
        bit [63:0] b = 64'h1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint push_axis(input longint d, input longint len, input longint s);
        longint u, sh, sl;
        u  = (d * 65536) / len;
        sh = s >>> 16;
        sl = s - sh * 65536;
        return u * sh + ((u * sl) >>> 16);
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void add_neighbor(input logic [IN_TDATA_W-1:0] d_in);
        longint d[3], len, gap, mg, r, r2, f, wt, s;
        bit [63:0] lo, hi, a, sq;
        lo = 0;
        hi = 0;
        if (!d_in[223] || used_cnt >= COUNT_LIMIT) return;
        for (int i = 0; i < 3; i++) begin
            d[i] = self_pos[i] - longint'($signed(d_in[96 + 32*i +: 32]));
            a = d[i] < 0 ? -d[i] : d[i];
            sq = a * a;
            lo += sq;
            if (lo < sq) hi++;
        end
        if (hi == 0) len = sqrt_floor(lo);
        else len = 2 * sqrt_floor((lo >> 2) | (hi << 62));
        gap = len - self_rad - longint'(d_in[222:192]);
        mg = gap_min != 0 ? gap_min : 1;
        if (gap < mg || gap > sep_dist || len <= 0) return;
        r  = (gap * 65536) / sep_dist;
        r2 = (r * r) >>> 16;
        f  = 65536 - r2;
        wt = (sep_wt * f) >>> 16;
        s  = (wt * 65536) / gap;
        for (int i = 0; i < 3; i++) acc[i] = sat32(acc[i] + push_axis(d[i], len, s));
        used_cnt++;
    endfunction

    // returns 1 when the beat closes a batch and yields a force
    function automatic bit predict_force(input logic [IN_TDATA_W-1:0] d_in, input logic act,
                                         input logic lst, output force_res_t res);
        longint o[3];
        if (act == ACT_NEIGHBOR) begin
            add_neighbor(d_in);
        end else begin
            for (int i = 0; i < 3; i++) acc[i] = longint'($signed(d_in[32*i +: 32]));
            used_cnt = 0;
        end
        if (!lst) return 0;
        for (int i = 0; i < 3; i++) o[i] = used_cnt > 0 ? acc[i] / used_cnt : acc[i];
        res.fx = o[0][31:0];
        res.fy = o[1][31:0];
        res.fz = o[2][31:0];
        res.cnt = used_cnt[8:0];
        for (int i = 0; i < 3; i++) acc[i] = 0;
        used_cnt = 0;
        return 1;
    endfunction

    // monitor: configuration, accepted input beats, result beats
    always @(posedge aclk) begin
        force_res_t res, exp_r;
        typed_res_t t;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SELF_X:       self_pos[0] = longint'($signed(cfg_data));
                    REG_SELF_Y:       self_pos[1] = longint'($signed(cfg_data));
                    REG_SELF_Z:       self_pos[2] = longint'($signed(cfg_data));
                    REG_SELF_RADIUS:  self_rad = longint'(cfg_data[30:0]);
                    REG_SEP_DISTANCE: sep_dist = longint'(cfg_data[30:0]);
                    REG_SEP_WEIGHT:   sep_wt = longint'($signed(cfg_data));
                    REG_MIN_GAP:      gap_min = longint'(cfg_data[30:0]);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (force_q.size() == 0) begin
                    report("unexpected result", 64'd0, 64'(m_tdata[63:0]));
                end else begin
                    exp_r = force_q.pop_front();
                    if (m_tdata[31:0] !== exp_r.fx)
                        report("force_x", 64'(exp_r.fx), 64'(m_tdata[31:0]));
                    if (m_tdata[63:32] !== exp_r.fy)
                        report("force_y", 64'(exp_r.fy), 64'(m_tdata[63:32]));
                    if (m_tdata[95:64] !== exp_r.fz)
                        report("force_z", 64'(exp_r.fz), 64'(m_tdata[95:64]));
                    if (m_tdata[104:96] !== exp_r.cnt)
                        report("used_count", 64'(exp_r.cnt), 64'(m_tdata[104:96]));
                    if (m_tdata[111:105] !== '0)
                        report("fill bits", 64'd0, 64'(m_tdata[111:105]));
                end
            end
            if (s_tvalid && s_tready) begin
                if (predict_force(s_tdata, s_tuser, s_tlast, res)) begin
                    if (typed_q.size() != 0) begin
                        t = typed_q.pop_front();
                        if (t.typed) res = t.res;
                    end
                    force_q.push_back(res);
                end
            end
        end
    end

    // receiver: changing stall pattern, plus one long hold-off on request
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                hold_left = 3000;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_beat(input logic act, input logic [31:0] f0, f1, f2,
                             input logic [30:0] rad, input logic active, input logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tdata <= {active, rad, f2, f1, f0, f2, f1, f0};
        s_tuser <= act;
        s_tlast <= lst;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (force_q.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    // position within span of the agent on one axis, wrapping at 32 bits
    function automatic logic [31:0] near_self(input int axis, input longint span);
        longint r;
        r = longint'({$urandom(), $urandom()} & 64'h3fff_ffff_ffff_ffff);
        r = r % (2 * span + 1) - span;
        return 32'(self_pos[axis] + r);
    endfunction

    task automatic random_batch(input int n_nbr, input bit with_begin);
        logic [31:0] p[3];
        logic [30:0] rad;
        longint span;
        span = sep_dist * 2 + self_rad + 2;
        if (with_begin) begin
            if ($urandom_range(0, 3) == 0)
                send_beat(ACT_BEGIN, $urandom, $urandom, $urandom, 31'($urandom),
                          1'($urandom_range(0, 1)), n_nbr == 0);
            else
                send_beat(ACT_BEGIN, 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)),
                          32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)),
                          32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)),
                          31'($urandom), 1'($urandom_range(0, 1)), n_nbr == 0);
        end
        for (int k = 0; k < n_nbr; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                foreach (p[i]) p[i] = $urandom;
                rad = 31'($urandom);
            end else begin
                foreach (p[i]) p[i] = near_self(i, span);
                rad = 31'($urandom_range(0, 32'(sep_dist / 4 + 1)));
            end
            send_beat(ACT_NEIGHBOR, p[0], p[1], p[2], rad, $urandom_range(0, 9) != 0,
                      k == n_nbr - 1);
        end
    endtask

    task automatic set_phase(input int ph);
        logic [31:0] v[7];
        v[0] = $urandom;
        v[1] = $urandom;
        v[2] = $urandom;
        v[3] = $urandom_range(0, 32'h8000);
        v[4] = $urandom_range(1, 8) << 16;
        v[5] = 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
        v[6] = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32'h4000) : 32'd1;
        case (ph)
            0: begin
                v[0] = 32'h7fff_ffff; v[1] = 32'h8000_0000; v[2] = 32'h0;
                v[3] = 32'h7fff_ffff; v[4] = 32'h7fff_ffff; v[5] = 32'h8000_0000;
                v[6] = 32'h7fff_ffff;
            end
            1: begin
                v[4] = 32'h7fff_ffff; v[5] = 32'h7fff_ffff; v[6] = 32'h0; v[3] = 32'h0;
            end
            2: v[4] = 32'h0;
            3: begin
                v[3] = 32'hffff_ffff; v[6] = 32'hffff_fffe; v[5] = 32'h8000_0000;
            end
            default: ;
        endcase
        cfg_write(REG_SELF_X, v[0]);
        cfg_write(REG_SELF_Y, v[1]);
        cfg_write(REG_SELF_Z, v[2]);
        cfg_write(REG_SELF_RADIUS, v[3]);
        cfg_write(REG_SEP_DISTANCE, v[4]);
        cfg_write(REG_SEP_WEIGHT, v[5]);
        cfg_write(REG_MIN_GAP, v[6]);
    endtask

    initial begin
        stim_row_t rows[$];
        typed_res_t t;
        int goal;
        self_pos = '{0, 0, 0};
        self_rad = 0;
        sep_dist = 65536;
        sep_wt = 65536;
        gap_min = 1;
        acc = '{0, 0, 0};
        used_cnt = 0;

        rows = '{
            '{ACT_BEGIN, 32'h7fffffff, 32'h80000000, 32'h0, 31'h0, 1'b0, 1'b1, 1'b1,
              32'h7fffffff, 32'h80000000, 32'h0, 9'd0},
            '{ACT_BEGIN, 32'h80000000, 32'h7fffffff, 32'hffffffff, 31'h7fffffff, 1'b1, 1'b1,
              1'b1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 9'd0},
            '{ACT_NEIGHBOR, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b1, 1'b1,
              32'h0, 32'h0, 32'h0, 9'd0},
            '{ACT_BEGIN, 32'h10000, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0, 1'b0,
              32'h0, 32'h0, 32'h0, 9'd0},
            '{ACT_NEIGHBOR, 32'h8000, 32'h0, 32'h0, 31'h0, 1'b1, 1'b0, 1'b0,
              32'h0, 32'h0, 32'h0, 9'd0},
            '{ACT_NEIGHBOR, 32'h0, 32'hc000, 32'h0, 31'h2000, 1'b1, 1'b0, 1'b0,
              32'h0, 32'h0, 32'h0, 9'd0},
            '{ACT_NEIGHBOR, 32'h0, 32'h0, 32'h0, 31'h0, 1'b1, 1'b0, 1'b0,
              32'h0, 32'h0, 32'h0, 9'd0},
            '{ACT_NEIGHBOR, 32'h20000, 32'h0, 32'h0, 31'h0, 1'b1, 1'b0, 1'b0,
              32'h0, 32'h0, 32'h0, 9'd0},
            '{ACT_NEIGHBOR, 32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff, 1'b1,
              1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 9'd0},
            '{ACT_NEIGHBOR, 32'h0, 32'h0, 32'hffff8000, 31'h0, 1'b1, 1'b1, 1'b0,
              32'h0, 32'h0, 32'h0, 9'd0},
            '{ACT_NEIGHBOR, 32'h10000, 32'h0, 32'h0, 31'h0, 1'b1, 1'b1, 1'b0,
              32'h0, 32'h0, 32'h0, 9'd0},
            '{ACT_NEIGHBOR, 32'h1, 32'h0, 32'h0, 31'h0, 1'b1, 1'b1, 1'b0,
              32'h0, 32'h0, 32'h0, 9'd0},
            '{ACT_NEIGHBOR, 32'hffffffff, 32'hffffffff, 32'h0, 31'h0, 1'b1, 1'b1, 1'b0,
              32'h0, 32'h0, 32'h0, 9'd0}
        };

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) begin
            if (rows[i].last) begin
                t.typed = rows[i].chk;
                t.res = '{rows[i].ex, rows[i].ey, rows[i].ez, rows[i].ecnt};
                typed_q.push_back(t);
            end
            send_beat(rows[i].act, rows[i].f0, rows[i].f1, rows[i].f2, rows[i].rad,
                      rows[i].active, rows[i].last);
        end
        drain_results();

        // long receiver hold-off while short batches keep coming
        hold_req = 1;
        repeat (30) send_beat(ACT_BEGIN, $urandom, $urandom, $urandom, 31'($urandom),
                              1'b0, 1'b1);
        drain_results();

        cfg_write(REG_UNUSED, $urandom);
        goal = sent + RANDOM_ITEMS;
        for (int ph = 0; sent < goal; ph++) begin
            set_phase(ph);
            repeat (30) begin
                if ($urandom_range(0, 9) == 0)
                    random_batch($urandom_range(1, 3), 1'b0);
                else
                    random_batch($urandom_range(0, 6), 1'b1);
            end
            drain_results();
        end

        // fill the neighbor count past its limit
        set_phase(10);
        cfg_write(REG_SELF_RADIUS, 32'h0);
        cfg_write(REG_MIN_GAP, 32'h1);
        cfg_write(REG_SEP_DISTANCE, 32'h40000);
        send_beat(ACT_BEGIN, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0);
        for (int k = 0; k < COUNT_LIMIT + 4; k++)
            send_beat(ACT_NEIGHBOR, near_self(0, 32'h8000) | 32'h1000, near_self(1, 32'h8000),
                      near_self(2, 32'h8000), 31'h0, 1'b1, k == COUNT_LIMIT + 3);
        drain_results();

        if (err_count == 0) begin
            $display("separation_steering_force_test OK");
        end else begin
            $display("separation_steering_force_test NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
